### rtl/core/tsr_pkg.sv
package tsr_pkg;

   // Fixed widths of the transaction fields.
   localparam int TARGET_W    = 12;
   localparam int ROOT_W      = 6;
   localparam int COUNT_W     = 7;
   localparam int MAX_RESULTS = 64;

   // One queued job: the masked target and the verdict of the front end.
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic                no_rep;
   } tsr_item_type;

   // Fill status of the job queue.
   typedef struct packed {
      logic full;
      logic empty;
   } tsr_qstat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_PAIR,
      ST_FLUSH
   } tsr_state_type;

endpackage

### rtl/core/tsr_front.sv
module tsr_front #(
   parameter int VALUE_WIDTH = 12
) (
   input  logic                           start,
   input  tsr_pkg::tsr_qstat_type         q_stat,
   input  logic [tsr_pkg::TARGET_W-1:0]   req_target,
   output logic                           push,
   output tsr_pkg::tsr_item_type          push_item
);
   import tsr_pkg::*;

   logic [VALUE_WIDTH-1:0] value;
   logic                   zero_below;
   logic                   no_rep;

   assign value = req_target[VALUE_WIDTH-1:0];

   // A value of the form 4^k * (8m + 7) is never a sum of three squares.
   always_comb begin
      zero_below = 1'b1;
      no_rep     = 1'b0;
      for (int k = 0; 2 * k + 2 < VALUE_WIDTH; k++) begin
         if (zero_below && (value[2 * k +: 3] == 3'b111)) begin
            no_rep = 1'b1;
         end
         zero_below = zero_below & ~value[2 * k] & ~value[2 * k + 1];
      end
   end

   assign push             = start & ~q_stat.full;
   assign push_item.target = TARGET_W'(value);
   assign push_item.no_rep = no_rep;

endmodule

### rtl/core/tsr_queue.sv
module tsr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tsr_pkg::tsr_item_type  push_item,
   input  logic                   pop,
   output tsr_pkg::tsr_item_type  head_item,
   output tsr_pkg::tsr_qstat_type q_stat
);
   import tsr_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsr_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign q_stat.full  = (fill_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (fill_ff == '0);
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/tsr_back.sv
module tsr_back #(
   parameter int VALUE_WIDTH = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tsr_pkg::tsr_qstat_type       q_stat,
   input  tsr_pkg::tsr_item_type        head_item,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_first_root,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_second_root,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_third_root,
   output logic                         rsp_found,
   output logic [tsr_pkg::COUNT_W-1:0]  rsp_rep_count,
   output logic                         rsp_last
);
   import tsr_pkg::*;

   localparam int RW   = (VALUE_WIDTH + 1) / 2;
   localparam int SQ_W = 2 * RW;
   localparam logic [RW-1:0]   CMAX    = RW'((2 ** RW) - 1);
   localparam logic [SQ_W-1:0] CMAX_SQ = SQ_W'(((2 ** RW) - 1) * ((2 ** RW) - 1));

   tsr_state_type state_ff, state_in;

   logic [SQ_W-1:0]    x_ff, x_in;
   logic [SQ_W-1:0]    rem_ff, rem_in;
   logic [RW-1:0]      a_ff, a_in, b_ff, b_in, c_ff, c_in, top_ff, top_in;
   logic [SQ_W-1:0]    a_sq_ff, a_sq_in, b_sq_ff, b_sq_in;
   logic [SQ_W-1:0]    c_sq_ff, c_sq_in, top_sq_ff, top_sq_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [RW-1:0]      pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]  rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in, rsp_c_ff, rsp_c_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [SQ_W+1:0]    three_a;
   logic               a_done;
   logic [SQ_W-1:0]    rem_now;
   logic [SQ_W:0]      pair_sum;
   logic               hit, under;
   logic               narrow;
   logic               full_now;
   logic [SQ_W-1:0]    a_next_sq;

   // Shared comparisons of the walk.
   always_comb begin
      three_a   = {2'b00, a_sq_ff} + {1'b0, a_sq_ff, 1'b0};
      a_done    = three_a > {2'b00, x_ff};
      rem_now   = x_ff - a_sq_ff;
      pair_sum  = {1'b0, b_sq_ff} + {1'b0, c_sq_ff};
      hit       = pair_sum == {1'b0, rem_ff};
      under     = pair_sum < {1'b0, rem_ff};
      narrow    = (b_ff == c_ff) || ((b_ff + RW'(1)) == c_ff);
      full_now  = hit && (count_ff == COUNT_W'(MAX_RESULTS - 1));
      a_next_sq = a_sq_ff + SQ_W'({a_ff, 1'b0}) + SQ_W'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = head_item.no_rep ? ST_FLUSH : ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (a_done) begin
               state_in = ST_FLUSH;
            end else if (top_sq_ff <= rem_now) begin
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (full_now) begin
               state_in = ST_FLUSH;
            end else if (hit ? narrow : (b_ff == c_ff)) begin
               state_in = ST_SEEK;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and result register.
   always_comb begin
      pop          = 1'b0;
      x_in         = x_ff;
      rem_in       = rem_ff;
      a_in         = a_ff;
      a_sq_in      = a_sq_ff;
      b_in         = b_ff;
      b_sq_in      = b_sq_ff;
      c_in         = c_ff;
      c_sq_in      = c_sq_ff;
      top_in       = top_ff;
      top_sq_in    = top_sq_ff;
      count_in     = count_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      rsp_valid_in = 1'b0;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop       = 1'b1;
               x_in      = SQ_W'(head_item.target[VALUE_WIDTH-1:0]);
               a_in      = '0;
               a_sq_in   = '0;
               top_in    = CMAX;
               top_sq_in = CMAX_SQ;
               count_in  = '0;
            end
         end
         ST_SEEK: begin
            if (!a_done) begin
               if (top_sq_ff > rem_now) begin
                  top_in    = top_ff - RW'(1);
                  top_sq_in = top_sq_ff - SQ_W'({top_ff, 1'b0}) + SQ_W'(1);
               end else begin
                  b_in    = a_ff;
                  b_sq_in = a_sq_ff;
                  c_in    = top_ff;
                  c_sq_in = top_sq_ff;
                  rem_in  = rem_now;
               end
            end
         end
         ST_PAIR: begin
            if (hit) begin
               // The held triple is now known not to be the final one.
               if (count_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_a_in     = ROOT_W'(pa_ff);
                  rsp_b_in     = ROOT_W'(pb_ff);
                  rsp_c_in     = ROOT_W'(pc_ff);
                  rsp_found_in = 1'b1;
                  rsp_count_in = count_ff;
                  rsp_last_in  = 1'b0;
               end
               pa_in    = a_ff;
               pb_in    = b_ff;
               pc_in    = c_ff;
               count_in = count_ff + COUNT_W'(1);
               if (!full_now) begin
                  if (narrow) begin
                     a_in    = a_ff + RW'(1);
                     a_sq_in = a_next_sq;
                  end else begin
                     b_in    = b_ff + RW'(1);
                     b_sq_in = b_sq_ff + SQ_W'({b_ff, 1'b0}) + SQ_W'(1);
                     c_in    = c_ff - RW'(1);
                     c_sq_in = c_sq_ff - SQ_W'({c_ff, 1'b0}) + SQ_W'(1);
                  end
               end
            end else if (b_ff == c_ff) begin
               a_in    = a_ff + RW'(1);
               a_sq_in = a_next_sq;
            end else if (under) begin
               b_in    = b_ff + RW'(1);
               b_sq_in = b_sq_ff + SQ_W'({b_ff, 1'b0}) + SQ_W'(1);
            end else begin
               c_in    = c_ff - RW'(1);
               c_sq_in = c_sq_ff - SQ_W'({c_ff, 1'b0}) + SQ_W'(1);
            end
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_count_in = count_ff;
            if (count_ff == '0) begin
               rsp_a_in     = '0;
               rsp_b_in     = '0;
               rsp_c_in     = '0;
               rsp_found_in = 1'b0;
            end else begin
               rsp_a_in     = ROOT_W'(pa_ff);
               rsp_b_in     = ROOT_W'(pb_ff);
               rsp_c_in     = ROOT_W'(pc_ff);
               rsp_found_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      rem_ff       <= rem_in;
      a_ff         <= a_in;
      a_sq_ff      <= a_sq_in;
      b_ff         <= b_in;
      b_sq_ff      <= b_sq_in;
      c_ff         <= c_in;
      c_sq_ff      <= c_sq_in;
      top_ff       <= top_in;
      top_sq_ff    <= top_sq_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_root  = rsp_a_ff;
   assign rsp_second_root = rsp_b_ff;
   assign rsp_third_root  = rsp_c_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_rep_count   = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR |-> (a_ff <= b_ff) && (b_ff <= c_ff))
      else $error("pair walk left the ordered region");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_last_ff && (rsp_count_ff == '0))
      else $error("empty result is not a lone final result");

   a_triple_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |->
         (14'(rsp_a_ff) * 14'(rsp_a_ff) + 14'(rsp_b_ff) * 14'(rsp_b_ff)
          + 14'(rsp_c_ff) * 14'(rsp_c_ff)) == 14'(x_ff))
      else $error("emitted triple does not sum to the target");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff && !rsp_last_ff |=>
         !rsp_valid_ff || (rsp_count_ff == $past(rsp_count_ff) + COUNT_W'(1)))
      else $error("running count skipped within a target");

endmodule

### rtl/core/three_square_representations.sv
// Finds every triple a <= b <= c with a*a + b*b + c*c equal to the target and
// reports them in ascending order of (a, b, c), one result transaction each,
// with a running count and the final result marked by rsp_last. A target with
// no triple gives a single result with rsp_found low and rsp_rep_count zero.
// A transaction is accepted on a clock edge where start is high and busy is
// low. A front end masks the target to VALUE_WIDTH bits and recognizes values
// of the form 4^k * (8m + 7), which have no triple; a two-entry job queue then
// holds targets for the back end, so busy rises only when two jobs wait.
// The back end walks one step per clock: for each a it first lowers a shared
// c bound until c*c fits the remainder, then runs b upward and c downward
// toward each other; a target recognized in the front end skips the walk.
// Results appear on rsp_valid for exactly one cycle each and must be taken
// then, because the receiver cannot stall the block; consecutive results of
// one target may arrive on consecutive cycles.
module three_square_representations #(
   parameter int VALUE_WIDTH = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tsr_pkg::TARGET_W-1:0] req_target,
   output logic                         rsp_valid,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_first_root,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_second_root,
   output logic [tsr_pkg::ROOT_W-1:0]   rsp_third_root,
   output logic                         rsp_found,
   output logic [tsr_pkg::COUNT_W-1:0]  rsp_rep_count,
   output logic                         rsp_last
);
   import tsr_pkg::*;

   tsr_qstat_type q_stat;
   tsr_item_type  push_item;
   tsr_item_type  head_item;
   logic          push;
   logic          pop;

   // Busy only reflects queue space, so a new target can be taken while
   // the back end is still walking the previous one.
   assign busy = q_stat.full;

   tsr_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .start      (start),
      .q_stat     (q_stat),
      .req_target (req_target),
      .push       (push),
      .push_item  (push_item)
   );

   tsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   tsr_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_first_root  (rsp_first_root),
      .rsp_second_root (rsp_second_root),
      .rsp_third_root  (rsp_third_root),
      .rsp_found       (rsp_found),
      .rsp_rep_count   (rsp_rep_count),
      .rsp_last        (rsp_last)
   );

endmodule
